// File: rtl/core/lsti_pkg.sv
// shared types, constants and sine table for the l-system turtle interpreter
package lsti_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SINE_BITS   = 15;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int COORD_W = 24;
    localparam int ANGLE_W = 9;
    localparam int LEN_W   = 16;
    localparam int SYM_W   = 8;
    localparam int KIND_W  = 2;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam int FULL_TURN    = 360;
    localparam int HALF_TURN    = 180;
    localparam int QUARTER_TURN = 90;
    localparam int TRIG_IDX_W   = $clog2(QUARTER_TURN + 1);

    // scaled step: magnitude product, rounding carry, then shift by SINE_BITS-1
    localparam int PROD_W  = SINE_BITS + LEN_W;
    localparam int ROUND_W = PROD_W + 1;
    localparam int STEP_W  = ROUND_W - (SINE_BITS - 1);

    // register map, by word index
    localparam logic [REG_IDX_W-1:0] REG_STEP_LENGTH   = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_STEP    = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_START_X       = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_START_Y       = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_START_HEADING = REG_IDX_W'(4);

    localparam logic [LEN_W-1:0]   STEP_LENGTH_RESET   = LEN_W'(1280);
    localparam logic [ANGLE_W-1:0] ANGLE_STEP_RESET    = ANGLE_W'(10);
    localparam logic [COORD_W-1:0] START_X_RESET       = '0;
    localparam logic [COORD_W-1:0] START_Y_RESET       = '0;
    localparam logic [ANGLE_W-1:0] START_HEADING_RESET = ANGLE_W'(270);

    // symbols
    localparam logic [SYM_W-1:0] SYM_MOVE_FIRST = SYM_W'(8'h41);
    localparam logic [SYM_W-1:0] SYM_MOVE_LAST  = SYM_W'(8'h46);
    localparam logic [SYM_W-1:0] SYM_PLUS       = SYM_W'(8'h2B);
    localparam logic [SYM_W-1:0] SYM_MINUS      = SYM_W'(8'h2D);
    localparam logic [SYM_W-1:0] SYM_PUSH       = SYM_W'(8'h5B);
    localparam logic [SYM_W-1:0] SYM_POP        = SYM_W'(8'h5D);

    typedef enum logic [KIND_W-1:0] {
        KIND_SEGMENT   = 2'd0,
        KIND_OVERFLOW  = 2'd1,
        KIND_UNDERFLOW = 2'd2
    } kind_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ANGLE_W-1:0] h;
    } pose_t;

    typedef logic [SINE_BITS-1:0] sine_table_t [0:QUARTER_TURN];

    localparam logic [63:0] Q30_PI = 64'd3373259426;

    // quarter-wave sine, odd taylor series to degree 13 in q2.30
    function automatic sine_table_t build_sine_table();
        sine_table_t tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        longint      amp;
        int          sh;
        amp = longint'(1) << (SINE_BITS - 1);
        sh  = 31 - SINE_BITS;
        for (int d = 0; d <= QUARTER_TURN; d++) begin
            x    = (64'(d) * Q30_PI + 64'd90) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + longint'(term);
            if (sum < 0) sum = 0;
            v = (sum + (longint'(1) << (sh - 1))) >>> sh;
            if (v > amp) v = amp;
            if (d == 0) v = 0;
            if (d == QUARTER_TURN) v = amp;
            tab[d] = v[SINE_BITS-1:0];
        end
        return tab;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// File: rtl/core/lsystem_turtle_interpreter.sv
// l-system turtle interpreter: pose update, pose stack and segment output
//
// One symbol is accepted per cycle unless a result is held up at the output. The
// symbol is captured in an input register; when it advances, the pose is updated
// and any result is written to an output register. The clock is set by the pose
// path: heading wrap and quadrant fold, sine table lookup, one of two parallel
// 15 x 16 bit multiplies with rounding, and a 24-bit add. Symbols that give no
// result pass even while a segment or stack error waits on the output; a symbol
// with a result waits until the output register is free or is being read. The
// 16-entry pose stack is held in flip-flops and needs no clearing after reset.
// Writes to the start pose take effect at the next item that starts a new string;
// step length and turn angle apply from the next item processed.
module lsystem_turtle_interpreter (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lsti_pkg::ADDR_W-1:0]           paddr,
    input  logic [lsti_pkg::DATA_W-1:0]           pwdata,
    output logic [lsti_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    // symbol input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lsti_pkg::SYM_W-1:0]            s_symbol,
    input  logic                                  s_first,
    // result output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lsti_pkg::KIND_W-1:0]           m_kind,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_from_x,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_from_y,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_to_x,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_to_y
);

    typedef struct packed {
        logic                           neg;
        logic [lsti_pkg::SINE_BITS-1:0] mag;
    } trig_t;

    localparam logic [lsti_pkg::ANGLE_W-1:0] TURN_A =
        lsti_pkg::ANGLE_W'(lsti_pkg::FULL_TURN);
    localparam logic [lsti_pkg::ANGLE_W-1:0] HALF_A =
        lsti_pkg::ANGLE_W'(lsti_pkg::HALF_TURN);
    localparam logic [lsti_pkg::ANGLE_W-1:0] QUARTER_A =
        lsti_pkg::ANGLE_W'(lsti_pkg::QUARTER_TURN);
    localparam logic [lsti_pkg::ANGLE_W-1:0] THREE_QUARTER_A =
        lsti_pkg::ANGLE_W'(lsti_pkg::HALF_TURN + lsti_pkg::QUARTER_TURN);
    localparam logic [lsti_pkg::ROUND_W-1:0] ROUND_HALF =
        lsti_pkg::ROUND_W'(1) << (lsti_pkg::SINE_BITS - 2);
    localparam logic [lsti_pkg::DEPTH_W-1:0] DEPTH_FULL =
        lsti_pkg::DEPTH_W'(lsti_pkg::STACK_DEPTH);

    // fold an angle below a full turn onto the quarter-wave table
    function automatic trig_t sine_of(input logic [lsti_pkg::ANGLE_W-1:0] a);
        trig_t                           t;
        logic [lsti_pkg::ANGLE_W-1:0]    idx;
        if (a <= QUARTER_A) begin
            idx   = a;
            t.neg = 1'b0;
        end else if (a <= HALF_A) begin
            idx   = HALF_A - a;
            t.neg = 1'b0;
        end else if (a <= THREE_QUARTER_A) begin
            idx   = a - HALF_A;
            t.neg = 1'b1;
        end else begin
            idx   = TURN_A - a;
            t.neg = 1'b1;
        end
        t.mag = lsti_pkg::SINE_TABLE[idx[lsti_pkg::TRIG_IDX_W-1:0]];
        return t;
    endfunction

    // length times trig, rounded to nearest with ties away from zero
    function automatic logic [lsti_pkg::COORD_W-1:0] scale_step(
        input trig_t                        t,
        input logic [lsti_pkg::LEN_W-1:0]   len
    );
        logic [lsti_pkg::PROD_W-1:0]    prod;
        logic [lsti_pkg::ROUND_W-1:0]   rnd;
        logic [lsti_pkg::COORD_W-1:0]   ext;
        prod = lsti_pkg::PROD_W'(t.mag) * lsti_pkg::PROD_W'(len);
        rnd  = {1'b0, prod} + ROUND_HALF;
        ext  = lsti_pkg::COORD_W'(rnd[lsti_pkg::ROUND_W-1:lsti_pkg::SINE_BITS-1]);
        return t.neg ? (~ext + lsti_pkg::COORD_W'(1)) : ext;
    endfunction

    function automatic logic [lsti_pkg::ANGLE_W-1:0] wrap_angle(
        input logic [lsti_pkg::ANGLE_W-1:0] a
    );
        return (a >= TURN_A) ? (a - TURN_A) : a;
    endfunction

    // configuration registers
    logic [lsti_pkg::LEN_W-1:0]     step_length_reg;
    logic [lsti_pkg::ANGLE_W-1:0]   angle_step_reg;
    logic [lsti_pkg::COORD_W-1:0]   start_x_reg;
    logic [lsti_pkg::COORD_W-1:0]   start_y_reg;
    logic [lsti_pkg::ANGLE_W-1:0]   start_heading_reg;

    logic                           cfg_write;
    logic [lsti_pkg::REG_IDX_W-1:0] cfg_idx;

    // input stage
    logic                           in_valid_reg;
    logic [lsti_pkg::SYM_W-1:0]     in_symbol_reg;
    logic                           in_first_reg;

    // pose state
    logic [lsti_pkg::COORD_W-1:0]   pos_x_reg;
    logic [lsti_pkg::COORD_W-1:0]   pos_y_reg;
    logic [lsti_pkg::ANGLE_W-1:0]   heading_reg;
    logic [lsti_pkg::DEPTH_W-1:0]   depth_reg;
    lsti_pkg::pose_t                stack_mem [0:lsti_pkg::STACK_DEPTH-1];

    logic [lsti_pkg::COORD_W-1:0]   pos_x_next;
    logic [lsti_pkg::COORD_W-1:0]   pos_y_next;
    logic [lsti_pkg::ANGLE_W-1:0]   heading_next;
    logic [lsti_pkg::DEPTH_W-1:0]   depth_next;

    // output stage
    logic                           out_valid_reg;
    lsti_pkg::kind_t                out_kind_reg;
    logic [lsti_pkg::COORD_W-1:0]   out_from_x_reg;
    logic [lsti_pkg::COORD_W-1:0]   out_from_y_reg;
    logic [lsti_pkg::COORD_W-1:0]   out_to_x_reg;
    logic [lsti_pkg::COORD_W-1:0]   out_to_y_reg;

    logic                           out_valid_next;
    lsti_pkg::kind_t                kind_next;
    logic [lsti_pkg::COORD_W-1:0]   from_x_next;
    logic [lsti_pkg::COORD_W-1:0]   from_y_next;
    logic [lsti_pkg::COORD_W-1:0]   to_x_next;
    logic [lsti_pkg::COORD_W-1:0]   to_y_next;

    // work signals
    logic [lsti_pkg::COORD_W-1:0]   base_x;
    logic [lsti_pkg::COORD_W-1:0]   base_y;
    logic [lsti_pkg::ANGLE_W-1:0]   base_h;
    logic [lsti_pkg::DEPTH_W-1:0]   base_depth;
    logic [lsti_pkg::DEPTH_W-1:0]   depth_less;
    logic [lsti_pkg::ANGLE_W-1:0]   turn;
    logic [lsti_pkg::ANGLE_W:0]     h_plus;
    logic [lsti_pkg::ANGLE_W:0]     h_minus;
    logic [lsti_pkg::ANGLE_W:0]     h_cos;
    logic [lsti_pkg::COORD_W-1:0]   dx;
    logic [lsti_pkg::COORD_W-1:0]   dy;
    lsti_pkg::pose_t                top_pose;
    logic                           is_move;
    logic                           is_plus;
    logic                           is_minus;
    logic                           is_push;
    logic                           is_pop;
    logic                           push_ok;
    logic                           pop_ok;
    logic                           has_result;
    logic                           advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[lsti_pkg::ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_length_reg   <= lsti_pkg::STEP_LENGTH_RESET;
            angle_step_reg    <= lsti_pkg::ANGLE_STEP_RESET;
            start_x_reg       <= lsti_pkg::START_X_RESET;
            start_y_reg       <= lsti_pkg::START_Y_RESET;
            start_heading_reg <= lsti_pkg::START_HEADING_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                lsti_pkg::REG_STEP_LENGTH: begin
                    step_length_reg <= pwdata[lsti_pkg::LEN_W-1:0];
                end
                lsti_pkg::REG_ANGLE_STEP: begin
                    angle_step_reg <= pwdata[lsti_pkg::ANGLE_W-1:0];
                end
                lsti_pkg::REG_START_X: begin
                    start_x_reg <= pwdata[lsti_pkg::COORD_W-1:0];
                end
                lsti_pkg::REG_START_Y: begin
                    start_y_reg <= pwdata[lsti_pkg::COORD_W-1:0];
                end
                lsti_pkg::REG_START_HEADING: begin
                    start_heading_reg <= pwdata[lsti_pkg::ANGLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            lsti_pkg::REG_STEP_LENGTH:   prdata = lsti_pkg::DATA_W'(step_length_reg);
            lsti_pkg::REG_ANGLE_STEP:    prdata = lsti_pkg::DATA_W'(angle_step_reg);
            lsti_pkg::REG_START_X:       prdata = lsti_pkg::DATA_W'(start_x_reg);
            lsti_pkg::REG_START_Y:       prdata = lsti_pkg::DATA_W'(start_y_reg);
            lsti_pkg::REG_START_HEADING: prdata = lsti_pkg::DATA_W'(start_heading_reg);
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        // a new string starts from the configured pose with an empty stack
        if (in_first_reg) begin
            base_x     = start_x_reg;
            base_y     = start_y_reg;
            base_h     = wrap_angle(start_heading_reg);
            base_depth = '0;
        end else begin
            base_x     = pos_x_reg;
            base_y     = pos_y_reg;
            base_h     = heading_reg;
            base_depth = depth_reg;
        end

        turn    = wrap_angle(angle_step_reg);
        h_plus  = {1'b0, base_h} + {1'b0, turn};
        h_minus = {1'b0, base_h} + {1'b0, TURN_A} - {1'b0, turn};
        h_cos   = {1'b0, base_h} + {1'b0, QUARTER_A};
        if (h_plus >= {1'b0, TURN_A}) h_plus = h_plus - {1'b0, TURN_A};
        if (h_minus >= {1'b0, TURN_A}) h_minus = h_minus - {1'b0, TURN_A};
        if (h_cos >= {1'b0, TURN_A}) h_cos = h_cos - {1'b0, TURN_A};

        dx = scale_step(sine_of(h_cos[lsti_pkg::ANGLE_W-1:0]), step_length_reg);
        dy = scale_step(sine_of(base_h), step_length_reg);

        is_move  = (in_symbol_reg >= lsti_pkg::SYM_MOVE_FIRST) &&
                   (in_symbol_reg <= lsti_pkg::SYM_MOVE_LAST);
        is_plus  = in_symbol_reg == lsti_pkg::SYM_PLUS;
        is_minus = in_symbol_reg == lsti_pkg::SYM_MINUS;
        is_push  = in_symbol_reg == lsti_pkg::SYM_PUSH;
        is_pop   = in_symbol_reg == lsti_pkg::SYM_POP;

        push_ok    = is_push && (base_depth < DEPTH_FULL);
        pop_ok     = is_pop && (base_depth != '0);
        depth_less = base_depth - lsti_pkg::DEPTH_W'(1);
        top_pose   = stack_mem[depth_less[lsti_pkg::IDX_W-1:0]];
        has_result = is_move || (is_push && !push_ok) || (is_pop && !pop_ok);

        pos_x_next   = base_x;
        pos_y_next   = base_y;
        heading_next = base_h;
        depth_next   = base_depth;
        kind_next    = lsti_pkg::KIND_SEGMENT;
        from_x_next  = '0;
        from_y_next  = '0;
        to_x_next    = '0;
        to_y_next    = '0;

        if (is_move) begin
            from_x_next = base_x;
            from_y_next = base_y;
            to_x_next   = base_x + dx;
            to_y_next   = base_y + dy;
            pos_x_next  = to_x_next;
            pos_y_next  = to_y_next;
        end else if (is_plus) begin
            heading_next = h_plus[lsti_pkg::ANGLE_W-1:0];
        end else if (is_minus) begin
            heading_next = h_minus[lsti_pkg::ANGLE_W-1:0];
        end else if (push_ok) begin
            depth_next = base_depth + lsti_pkg::DEPTH_W'(1);
        end else if (pop_ok) begin
            depth_next   = depth_less;
            pos_x_next   = top_pose.x;
            pos_y_next   = top_pose.y;
            heading_next = top_pose.h;
        end else if (is_push) begin
            kind_next = lsti_pkg::KIND_OVERFLOW;
        end else if (is_pop) begin
            kind_next = lsti_pkg::KIND_UNDERFLOW;
        end
    end

    // only an item with a result has to wait for the output register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready || !has_result);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        if (advance && has_result) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= lsti_pkg::START_X_RESET;
            pos_y_reg     <= lsti_pkg::START_Y_RESET;
            heading_reg   <= lsti_pkg::START_HEADING_RESET;
            depth_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                pos_x_reg   <= pos_x_next;
                pos_y_reg   <= pos_y_next;
                heading_reg <= heading_next;
                depth_reg   <= depth_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_symbol_reg <= s_symbol;
            in_first_reg  <= s_first;
        end
        if (advance && has_result) begin
            out_kind_reg   <= kind_next;
            out_from_x_reg <= from_x_next;
            out_from_y_reg <= from_y_next;
            out_to_x_reg   <= to_x_next;
            out_to_y_reg   <= to_y_next;
        end
        if (advance && push_ok) begin
            stack_mem[base_depth[lsti_pkg::IDX_W-1:0]] <= '{x: base_x, y: base_y, h: base_h};
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_kind   = out_kind_reg;
    assign m_from_x = out_from_x_reg;
    assign m_from_y = out_from_y_reg;
    assign m_to_x   = out_to_x_reg;
    assign m_to_y   = out_to_y_reg;

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        heading_reg < TURN_A)
        else $error("heading left the range of a full turn");

    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_FULL)
        else $error("stack depth beyond capacity");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg != lsti_pkg::KIND_SEGMENT) |->
        (out_from_x_reg == '0 && out_from_y_reg == '0 &&
         out_to_x_reg == '0 && out_to_y_reg == '0))
        else $error("stack error item carries coordinates");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_push_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && push_ok && !in_first_reg) |=>
        (depth_reg == $past(depth_reg) + lsti_pkg::DEPTH_W'(1)))
        else $error("successful push did not grow the stack");

endmodule

// File: verif/lsti_turtle_check.sv
// checker: predicts turtle segments and stack errors and compares them with the result channel
module lsti_turtle_check (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [lsti_pkg::ADDR_W-1:0]          paddr,
    input  logic [lsti_pkg::DATA_W-1:0]          pwdata,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [lsti_pkg::SYM_W-1:0]           s_symbol,
    input  logic                                 s_first,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [lsti_pkg::KIND_W-1:0]          m_kind,
    input  logic [lsti_pkg::COORD_W-1:0]         m_from_x,
    input  logic [lsti_pkg::COORD_W-1:0]         m_from_y,
    input  logic [lsti_pkg::COORD_W-1:0]         m_to_x,
    input  logic [lsti_pkg::COORD_W-1:0]         m_to_y,
    output int                                   mismatches,
    output int                                   outstanding
);

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam int SHOWN = 10;

    typedef struct packed {
        lsti_pkg::kind_t                kind;
        logic [lsti_pkg::COORD_W-1:0]   from_x;
        logic [lsti_pkg::COORD_W-1:0]   from_y;
        logic [lsti_pkg::COORD_W-1:0]   to_x;
        logic [lsti_pkg::COORD_W-1:0]   to_y;
    } mark_t;

    int sine_q [0:lsti_pkg::QUARTER_TURN];

    logic [lsti_pkg::LEN_W-1:0]   step_len;
    logic [lsti_pkg::ANGLE_W-1:0] turn_reg;
    logic [lsti_pkg::COORD_W-1:0] home_x;
    logic [lsti_pkg::COORD_W-1:0] home_y;
    logic [lsti_pkg::ANGLE_W-1:0] home_heading;

    logic [lsti_pkg::COORD_W-1:0] cur_x;
    logic [lsti_pkg::COORD_W-1:0] cur_y;
    int unsigned                  cur_h;
    lsti_pkg::pose_t              pose_stack [lsti_pkg::STACK_DEPTH];
    int                           stack_fill;

    mark_t due_marks [$];
    int    fail_count = 0;

    // quarter-wave sine by odd taylor terms up to x^13, in q2.30
    function automatic void fill_sine();
        logic [63:0] ang;
        logic [63:0] ang2;
        logic [63:0] term;
        longint      acc;
        longint      q;
        longint      amp;
        int          shift;
        amp   = longint'(1) << (lsti_pkg::SINE_BITS - 1);
        shift = 31 - lsti_pkg::SINE_BITS;
        for (int d = 0; d <= lsti_pkg::QUARTER_TURN; d++) begin
            ang  = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = longint'(ang);
            for (int n = 1; n <= 6; n++) begin
                term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            q = (acc + (longint'(1) << (shift - 1))) >>> shift;
            if (q > amp) q = amp;
            if (d == 0) q = 0;
            if (d == lsti_pkg::QUARTER_TURN) q = amp;
            sine_q[d] = int'(q);
        end
    endfunction

    function automatic int sine_at(int unsigned deg);
        int unsigned a;
        a = deg % lsti_pkg::FULL_TURN;
        if (a <= lsti_pkg::QUARTER_TURN) return sine_q[a];
        if (a <= lsti_pkg::HALF_TURN) return sine_q[lsti_pkg::HALF_TURN - a];
        if (a <= lsti_pkg::HALF_TURN + lsti_pkg::QUARTER_TURN)
            return -sine_q[a - lsti_pkg::HALF_TURN];
        return -sine_q[lsti_pkg::FULL_TURN - a];
    endfunction

    // magnitude times length, rounded half away from zero back to q.8
    function automatic int scaled(int trig, logic [lsti_pkg::LEN_W-1:0] len);
        longint mag;
        mag = longint'(trig < 0 ? -trig : trig) * longint'(len);
        mag = (mag + (longint'(1) << (lsti_pkg::SINE_BITS - 2))) >>> (lsti_pkg::SINE_BITS - 1);
        return int'(trig < 0 ? -mag : mag);
    endfunction

    function automatic void go_home();
        cur_x      = home_x;
        cur_y      = home_y;
        cur_h      = home_heading % lsti_pkg::FULL_TURN;
        stack_fill = 0;
    endfunction

    function automatic void queue_mark(mark_t m);
        due_marks.insert(due_marks.size(), m);
    endfunction

    function automatic void write_reg(logic [lsti_pkg::REG_IDX_W-1:0] idx,
                                      logic [lsti_pkg::DATA_W-1:0] data);
        case (idx)
            lsti_pkg::REG_STEP_LENGTH:   step_len     = data[lsti_pkg::LEN_W-1:0];
            lsti_pkg::REG_ANGLE_STEP:    turn_reg     = data[lsti_pkg::ANGLE_W-1:0];
            lsti_pkg::REG_START_X:       home_x       = data[lsti_pkg::COORD_W-1:0];
            lsti_pkg::REG_START_Y:       home_y       = data[lsti_pkg::COORD_W-1:0];
            lsti_pkg::REG_START_HEADING: home_heading = data[lsti_pkg::ANGLE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void interpret_symbol(logic [lsti_pkg::SYM_W-1:0] sym, logic fresh);
        mark_t       m;
        int          dx;
        int          dy;
        int unsigned turn;
        m    = '0;
        turn = turn_reg % lsti_pkg::FULL_TURN;
        if (fresh) go_home();
        if (sym >= lsti_pkg::SYM_MOVE_FIRST && sym <= lsti_pkg::SYM_MOVE_LAST) begin
            dx       = scaled(sine_at(cur_h + lsti_pkg::QUARTER_TURN), step_len);
            dy       = scaled(sine_at(cur_h), step_len);
            m.kind   = lsti_pkg::KIND_SEGMENT;
            m.from_x = cur_x;
            m.from_y = cur_y;
            m.to_x   = cur_x + lsti_pkg::COORD_W'(dx);
            m.to_y   = cur_y + lsti_pkg::COORD_W'(dy);
            cur_x    = m.to_x;
            cur_y    = m.to_y;
            queue_mark(m);
        end else if (sym == lsti_pkg::SYM_PLUS) begin
            cur_h = (cur_h + turn) % lsti_pkg::FULL_TURN;
        end else if (sym == lsti_pkg::SYM_MINUS) begin
            cur_h = (cur_h + lsti_pkg::FULL_TURN - turn) % lsti_pkg::FULL_TURN;
        end else if (sym == lsti_pkg::SYM_PUSH) begin
            if (stack_fill < lsti_pkg::STACK_DEPTH) begin
                pose_stack[stack_fill].x = cur_x;
                pose_stack[stack_fill].y = cur_y;
                pose_stack[stack_fill].h = lsti_pkg::ANGLE_W'(cur_h);
                stack_fill++;
            end else begin
                m.kind = lsti_pkg::KIND_OVERFLOW;
                queue_mark(m);
            end
        end else if (sym == lsti_pkg::SYM_POP) begin
            if (stack_fill > 0) begin
                stack_fill--;
                cur_x = pose_stack[stack_fill].x;
                cur_y = pose_stack[stack_fill].y;
                cur_h = pose_stack[stack_fill].h % lsti_pkg::FULL_TURN;
            end else begin
                m.kind = lsti_pkg::KIND_UNDERFLOW;
                queue_mark(m);
            end
        end
    endfunction

    function automatic void report(string what, mark_t want, mark_t got);
        string w;
        string g;
        fail_count++;
        if (fail_count <= SHOWN) begin
            w = $sformatf("kind %0d (%0d,%0d)->(%0d,%0d)", want.kind,
                          $signed(want.from_x), $signed(want.from_y),
                          $signed(want.to_x), $signed(want.to_y));
            g = $sformatf("kind %0d (%0d,%0d)->(%0d,%0d)", got.kind,
                          $signed(got.from_x), $signed(got.from_y),
                          $signed(got.to_x), $signed(got.to_y));
            $display("%s: expected %s, got %s", what, w, g);
        end
    endfunction

    initial begin
        fill_sine();
    end

    always @(posedge aclk) begin
        mark_t got;
        mark_t want;
        if (!aresetn) begin
            step_len     = lsti_pkg::STEP_LENGTH_RESET;
            turn_reg     = lsti_pkg::ANGLE_STEP_RESET;
            home_x       = lsti_pkg::START_X_RESET;
            home_y       = lsti_pkg::START_Y_RESET;
            home_heading = lsti_pkg::START_HEADING_RESET;
            go_home();
            due_marks.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                write_reg(paddr[lsti_pkg::ADDR_W-1:2], pwdata);
            if (s_valid && s_ready)
                interpret_symbol(s_symbol, s_first);
            if (m_valid && m_ready) begin
                got.kind   = lsti_pkg::kind_t'(m_kind);
                got.from_x = m_from_x;
                got.from_y = m_from_y;
                got.to_x   = m_to_x;
                got.to_y   = m_to_y;
                if (due_marks.size() == 0) begin
                    report("result with nothing due", '0, got);
                end else begin
                    want = due_marks.pop_front();
                    if (got !== want) report("wrong result", want, got);
                end
            end
        end
        mismatches  <= fail_count;
        outstanding <= due_marks.size();
    end

endmodule

// File: verif/tb_lsystem_turtle_interpreter.sv
// testbench top: symbol strings, register settings and the verdict for the turtle interpreter
module tb_lsystem_turtle_interpreter;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 8;
    localparam int HOLD_OFF    = 4;
    localparam int PHASE_ITEMS = 185;
    localparam int PHASES      = 7;

    // word indexes past the register map, writes there must be ignored
    localparam logic [lsti_pkg::REG_IDX_W-1:0] REG_UNUSED_LOW = lsti_pkg::REG_IDX_W'(5);
    localparam logic [lsti_pkg::REG_IDX_W-1:0] REG_UNUSED_TOP = lsti_pkg::REG_IDX_W'(7);

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [lsti_pkg::ADDR_W-1:0]     paddr    = '0;
    logic [lsti_pkg::DATA_W-1:0]     pwdata   = '0;
    logic [lsti_pkg::DATA_W-1:0]     prdata;
    logic                            pready;
    logic                            s_valid  = 1'b0;
    logic                            s_ready;
    logic [lsti_pkg::SYM_W-1:0]      s_symbol = '0;
    logic                            s_first  = 1'b0;
    logic                            m_valid;
    logic                            m_ready  = 1'b0;
    logic [lsti_pkg::KIND_W-1:0]     m_kind;
    logic [lsti_pkg::COORD_W-1:0]    m_from_x;
    logic [lsti_pkg::COORD_W-1:0]    m_from_y;
    logic [lsti_pkg::COORD_W-1:0]    m_to_x;
    logic [lsti_pkg::COORD_W-1:0]    m_to_y;

    int   errors;
    int   outstanding;
    int   quiet_cycles = 0;
    int   sent_items   = 0;
    logic calm         = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    lsystem_turtle_interpreter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_symbol (s_symbol),
        .s_first  (s_first),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_kind   (m_kind),
        .m_from_x (m_from_x),
        .m_from_y (m_from_y),
        .m_to_x   (m_to_x),
        .m_to_y   (m_to_y)
    );

    lsti_turtle_check turtle_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_symbol    (s_symbol),
        .s_first     (s_first),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_from_x    (m_from_x),
        .m_from_y    (m_from_y),
        .m_to_x      (m_to_x),
        .m_to_y      (m_to_y),
        .mismatches  (errors),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_symbol(input logic [lsti_pkg::SYM_W-1:0] sym, input logic fresh);
        while (!calm && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_symbol <= sym;
        s_first  <= fresh;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sent_items++;
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [lsti_pkg::REG_IDX_W-1:0] idx,
                             input logic [lsti_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [lsti_pkg::DATA_W-1:0] len,
                               input logic [lsti_pkg::DATA_W-1:0] turn,
                               input logic [lsti_pkg::DATA_W-1:0] sx,
                               input logic [lsti_pkg::DATA_W-1:0] sy,
                               input logic [lsti_pkg::DATA_W-1:0] hd);
        // a turn or a push may still be in the pipe with no result behind it
        wait_results_done();
        repeat (HOLD_OFF) @(posedge aclk);
        write_reg(lsti_pkg::REG_STEP_LENGTH, len);
        write_reg(lsti_pkg::REG_ANGLE_STEP, turn);
        write_reg(lsti_pkg::REG_START_X, sx);
        write_reg(lsti_pkg::REG_START_Y, sy);
        write_reg(lsti_pkg::REG_START_HEADING, hd);
    endtask

    // one string: mostly balanced turtle programs, some stack storms and noise
    task automatic play_string();
        logic [lsti_pkg::SYM_W:0]   chars [$];
        logic [lsti_pkg::SYM_W-1:0] sym;
        int                         len;
        int                         nest;
        int                         limit;
        int                         pick;
        if ($urandom_range(0, 99) < 75) begin
            limit = ($urandom_range(0, 7) == 0) ? lsti_pkg::STACK_DEPTH + 3
                                                : $urandom_range(1, 6);
            nest  = 0;
            len   = $urandom_range(4, 40);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    sym = lsti_pkg::SYM_MOVE_FIRST + lsti_pkg::SYM_W'($urandom_range(0, 5));
                end else if (pick < 62) begin
                    sym = pick[0] ? lsti_pkg::SYM_PLUS : lsti_pkg::SYM_MINUS;
                end else if (pick < 80 && nest < limit) begin
                    sym = lsti_pkg::SYM_PUSH;
                    nest++;
                end else if (pick < 96 && nest > 0) begin
                    sym = lsti_pkg::SYM_POP;
                    nest--;
                end else begin
                    sym = lsti_pkg::SYM_W'($urandom_range(0, 255));
                end
                chars.insert(chars.size(), {1'b0, sym});
            end
            repeat (nest) chars.insert(chars.size(), {1'b0, lsti_pkg::SYM_POP});
            chars[0][lsti_pkg::SYM_W] = ($urandom_range(0, 9) != 0);
        end else if ($urandom_range(0, 2) == 0) begin
            // a run of pushes near or past the top of the stack, then pops near or past the bottom
            repeat ($urandom_range(lsti_pkg::STACK_DEPTH - 2, lsti_pkg::STACK_DEPTH + 4))
                chars.insert(chars.size(), {1'b0, lsti_pkg::SYM_PUSH});
            repeat ($urandom_range(1, 4))
                chars.insert(chars.size(), {1'b0, lsti_pkg::SYM_MOVE_FIRST +
                                            lsti_pkg::SYM_W'($urandom_range(0, 5))});
            repeat ($urandom_range(lsti_pkg::STACK_DEPTH - 2, lsti_pkg::STACK_DEPTH + 4))
                chars.insert(chars.size(), {1'b0, lsti_pkg::SYM_POP});
        end else begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 5))
                    0:       sym = lsti_pkg::SYM_MOVE_FIRST +
                                   lsti_pkg::SYM_W'($urandom_range(0, 5));
                    1:       sym = $urandom_range(0, 1) ? lsti_pkg::SYM_PLUS
                                                        : lsti_pkg::SYM_MINUS;
                    2:       sym = lsti_pkg::SYM_PUSH;
                    3:       sym = lsti_pkg::SYM_POP;
                    default: sym = lsti_pkg::SYM_W'($urandom_range(0, 255));
                endcase
                chars.insert(chars.size(), {$urandom_range(0, 99) < 15, sym});
            end
        end
        foreach (chars[i]) send_symbol(chars[i][lsti_pkg::SYM_W-1:0], chars[i][lsti_pkg::SYM_W]);
    endtask

    initial begin
        int   goal;
        logic paused;
        paused = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: every move letter, both turns, empty-stack pop
        send_symbol(lsti_pkg::SYM_MOVE_FIRST + 8'd4, 1'b1);
        send_symbol(lsti_pkg::SYM_MOVE_FIRST, 1'b0);
        send_symbol(lsti_pkg::SYM_PLUS, 1'b0);
        send_symbol(lsti_pkg::SYM_MOVE_FIRST + 8'd1, 1'b0);
        send_symbol(lsti_pkg::SYM_MINUS, 1'b0);
        send_symbol(lsti_pkg::SYM_MINUS, 1'b0);
        send_symbol(lsti_pkg::SYM_MOVE_FIRST + 8'd2, 1'b0);
        send_symbol(lsti_pkg::SYM_POP, 1'b0);
        send_symbol(lsti_pkg::SYM_PUSH, 1'b0);
        send_symbol(lsti_pkg::SYM_PLUS, 1'b0);
        send_symbol(lsti_pkg::SYM_MOVE_FIRST + 8'd3, 1'b0);
        send_symbol(lsti_pkg::SYM_POP, 1'b0);
        send_symbol(lsti_pkg::SYM_MOVE_LAST, 1'b0);
        // neighbours of the move range and the byte extremes do nothing
        send_symbol(lsti_pkg::SYM_MOVE_FIRST - 8'd1, 1'b0);
        send_symbol(lsti_pkg::SYM_MOVE_LAST + 8'd1, 1'b0);
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b0);
        repeat (lsti_pkg::STACK_DEPTH + 1) send_symbol(lsti_pkg::SYM_PUSH, 1'b0);
        // a new string empties the stack, so this pop underflows
        send_symbol(lsti_pkg::SYM_MOVE_FIRST, 1'b1);
        send_symbol(lsti_pkg::SYM_POP, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: load_config(32'h0000_FFFF, 32'd359, 32'h007F_FFFF, 32'h0080_0000, 32'd359);
                2: load_config(32'd0, 32'd0, 32'h0080_0000, 32'h007F_FFFF, 32'd0);
                3: begin
                    // angles above a full turn, and writes outside the map
                    load_config(32'd256, 32'd511, 32'd0, 32'd0, 32'd511);
                    write_reg(REG_UNUSED_LOW, $urandom);
                    write_reg(REG_UNUSED_TOP, $urandom);
                end
                4: begin
                    load_config(32'd1280, 32'd90, $urandom, $urandom, 32'd90);
                    calm <= 1'b1;
                end
                5: begin
                    calm <= 1'b0;
                    load_config($urandom, $urandom, $urandom, $urandom, $urandom);
                end
                6: load_config($urandom_range(1, 4096), 32'(15 * $urandom_range(1, 4)),
                               $urandom, $urandom, $urandom_range(0, 359));
                default: ;
            endcase
            goal = sent_items + PHASE_ITEMS;
            while (sent_items < goal) begin
                if (p == 5 && !paused && sent_items >= goal - PHASE_ITEMS / 2) begin
                    wait_results_done();
                    paused = 1'b1;
                end
                play_string();
            end
        end

        wait_results_done();
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lsti_pkg.sv
rtl/core/lsystem_turtle_interpreter.sv
verif/lsti_turtle_check.sv
verif/tb_lsystem_turtle_interpreter.sv
